[rtl/core/hcg_pkg.sv]
// Shared types and constants of the hit coincidence grouper.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package hcg_pkg;

    localparam int HCG_TIME_W = 48;  // time field width on the ports
    localparam int HCG_CH_W   = 16;  // channel id and register width
    localparam int HCG_MULT_W = 3;   // multiplicity field width
    localparam int HCG_ADDR_W = 5;   // byte address of five 32-bit registers
    localparam int HCG_DATA_W = 32;
    localparam int HCG_NUM_CH = 4;

    // Default window is 20 ns in 1/16 ns ticks.
    localparam int HCG_WINDOW_NS = 20;
    localparam logic [HCG_CH_W-1:0] HCG_WINDOW_RST = HCG_CH_W'(HCG_WINDOW_NS * 16);
    localparam logic [HCG_CH_W-1:0] HCG_CH_A_RST = 16'd681;
    localparam logic [HCG_CH_W-1:0] HCG_CH_B_RST = 16'd682;
    localparam logic [HCG_CH_W-1:0] HCG_CH_C_RST = 16'd683;
    localparam logic [HCG_CH_W-1:0] HCG_CH_D_RST = 16'd684;

    // Register index, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_WINDOW = 3'd0,
        REG_CH_A   = 3'd1,
        REG_CH_B   = 3'd2,
        REG_CH_C   = 3'd3,
        REG_CH_D   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [HCG_CH_W-1:0]                  window;
        logic [HCG_NUM_CH-1:0][HCG_CH_W-1:0]  chan;
    } t_cfg;

    // A hit after the input register: channel match already resolved.
    typedef struct packed {
        logic                  ok;
        logic [HCG_TIME_W-1:0] hit_ts;
        logic                  last;
    } t_hit;

endpackage

`default_nettype wire

[rtl/core/hcg_if.sv]
// Handshake channel interfaces for hit words and coincidence words.
// Depends on hcg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hcg_hit_if;
    logic                           valid;
    logic                           ready;
    logic [hcg_pkg::HCG_CH_W-1:0]   channel_id;
    logic [hcg_pkg::HCG_TIME_W-1:0] hit_time;
    logic                           last_hit;

    modport source (output valid, output channel_id, output hit_time, output last_hit,
                    input ready);
    modport sink   (input valid, input channel_id, input hit_time, input last_hit,
                    output ready);
endinterface

interface hcg_coinc_if;
    logic                           valid;
    logic                           ready;
    logic [hcg_pkg::HCG_TIME_W-1:0] coincidence_time;
    logic [hcg_pkg::HCG_MULT_W-1:0] multiplicity;

    modport source (output valid, output coincidence_time, output multiplicity,
                    input ready);
    modport sink   (input valid, input coincidence_time, input multiplicity,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/hcg_cfg_regs.sv]
// APB configuration registers: window and the four accepted channel ids.
// Depends on hcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcg_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcg_pkg::HCG_ADDR_W-1:0] paddr,
    input  logic [hcg_pkg::HCG_DATA_W-1:0] pwdata,
    output logic [hcg_pkg::HCG_DATA_W-1:0] prdata,
    output logic                           pready,
    output hcg_pkg::t_cfg                  o_cfg
);
    import hcg_pkg::*;

    t_cfg                r_cfg;
    logic                w_wr;
    t_reg_idx            w_idx;
    logic [HCG_CH_W-1:0] w_data;
    logic [HCG_CH_W-1:0] w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[HCG_ADDR_W-1:2]);
    assign w_data = pwdata[HCG_CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window  <= HCG_WINDOW_RST;
            r_cfg.chan[0] <= HCG_CH_A_RST;
            r_cfg.chan[1] <= HCG_CH_B_RST;
            r_cfg.chan[2] <= HCG_CH_C_RST;
            r_cfg.chan[3] <= HCG_CH_D_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WINDOW: r_cfg.window  <= w_data;
                REG_CH_A:   r_cfg.chan[0] <= w_data;
                REG_CH_B:   r_cfg.chan[1] <= w_data;
                REG_CH_C:   r_cfg.chan[2] <= w_data;
                REG_CH_D:   r_cfg.chan[3] <= w_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WINDOW: w_rd = r_cfg.window;
            REG_CH_A:   w_rd = r_cfg.chan[0];
            REG_CH_B:   w_rd = r_cfg.chan[1];
            REG_CH_C:   w_rd = r_cfg.chan[2];
            REG_CH_D:   w_rd = r_cfg.chan[3];
            default:    w_rd = '0;
        endcase
    end

    assign prdata = HCG_DATA_W'(w_rd);
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

[rtl/core/hcg_hit_filter.sv]
// Input register of the grouper; resolves the channel match on the way in.
// Depends on hcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcg_hit_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hcg_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hcg_pkg::HCG_CH_W-1:0]   i_channel_id,
    input  logic [hcg_pkg::HCG_TIME_W-1:0] i_hit_time,
    input  logic                           i_last_hit,
    output logic                           o_valid,
    input  logic                           i_ready,
    output hcg_pkg::t_hit                  o_hit
);
    import hcg_pkg::*;

    logic                  r_valid;
    t_hit                  r_hit;
    logic [HCG_NUM_CH-1:0] w_match;

    // A duplicated channel register simply matches twice.
    always_comb begin
        for (int k = 0; k < HCG_NUM_CH; k++) begin
            w_match[k] = (i_channel_id == i_cfg.chan[k]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_hit.ok     <= |w_match;
            r_hit.hit_ts <= i_hit_time;
            r_hit.last   <= i_last_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

[rtl/core/hcg_group_core.sv]
// Group state and result register: window compare, group count, flush.
// Depends on hcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcg_group_core #(
    parameter int TIME_W   = 48,
    parameter int MAX_MULT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hcg_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  hcg_pkg::t_hit                  i_hit,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [hcg_pkg::HCG_TIME_W-1:0] o_out_time,
    output logic [hcg_pkg::HCG_MULT_W-1:0] o_out_mult
);
    import hcg_pkg::*;

    localparam logic [HCG_MULT_W-1:0] MaxSize = HCG_MULT_W'(MAX_MULT);
    localparam logic [HCG_MULT_W-1:0] Pair    = HCG_MULT_W'(2);
    localparam logic [HCG_MULT_W-1:0] One     = HCG_MULT_W'(1);

    logic [TIME_W-1:0]     r_start;
    logic [HCG_MULT_W-1:0] r_size;
    logic                  r_out_valid;
    logic [TIME_W-1:0]     r_out_time;
    logic [HCG_MULT_W-1:0] r_out_mult;

    logic [TIME_W-1:0]     n_start;
    logic [HCG_MULT_W-1:0] n_size;
    logic                  w_emit;
    logic [HCG_MULT_W-1:0] w_emit_size;
    logic [TIME_W-1:0]     w_t;
    logic [TIME_W-1:0]     w_dist;
    logic                  w_in_win;
    logic [HCG_MULT_W-1:0] w_size_inc;
    logic                  w_adv;

    assign w_adv   = i_valid && (!r_out_valid || i_out_ready);
    assign o_ready = w_adv || !i_valid;

    assign w_t        = i_hit.hit_ts[TIME_W-1:0];
    assign w_dist     = (w_t >= r_start) ? (w_t - r_start) : (r_start - w_t);
    assign w_in_win   = w_dist < TIME_W'(i_cfg.window);
    assign w_size_inc = r_size + One;

    always_comb begin
        n_start     = r_start;
        n_size      = r_size;
        w_emit      = 1'b0;
        w_emit_size = r_size;
        if (i_hit.ok) begin
            if (r_size == '0) begin
                n_start = w_t;
                n_size  = One;
            end else if (w_in_win) begin
                if (w_size_inc >= MaxSize) begin
                    w_emit      = 1'b1;
                    w_emit_size = w_size_inc;
                    n_size      = '0;
                end else begin
                    n_size = w_size_inc;
                end
            end else begin
                // Hit outside the window closes the group and opens its own.
                w_emit      = (r_size >= Pair);
                w_emit_size = r_size;
                n_start     = w_t;
                n_size      = One;
            end
        end
        if (i_hit.last) begin
            // A group that survives to the flush still starts at r_start.
            if (n_size >= Pair && !w_emit) begin
                w_emit      = 1'b1;
                w_emit_size = n_size;
            end
            n_size = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_size      <= n_size;
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_start <= n_start;
            if (w_emit) begin
                r_out_time <= r_start;
                r_out_mult <= w_emit_size;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_time  = HCG_TIME_W'(r_out_time);
    assign o_out_mult  = r_out_mult;

endmodule

`default_nettype wire

[rtl/core/hit_coincidence_grouper_unit.sv]
// Top level of the hit coincidence grouper: APB registers, input stage, group core.
// Depends on hcg_pkg, hcg_if, hcg_cfg_regs, hcg_hit_filter and hcg_group_core.
//
// Usage: hit words (channel_id, hit_time, last_hit) arrive in time order on the
// i_hit channel, and coincidence words (coincidence_time, multiplicity) leave on
// o_coinc. Both channels move a word at a rising edge where valid and ready are
// high. Hits on channels other than the four programmed ids are dropped. Hits
// within window_ticks of a group's first hit join it; a group of two or more
// hits gives one coincidence word, and a group that fills up closes at once.
// A word with last_hit set flushes the open group.
// The hit word that closes a group passes the input register first; its
// coincidence word then loads into the result register once that register is
// free, and is held there on o_coinc until it moves.
// Throughput: one hit word per cycle while o_coinc does not stall; the
// window compare and the group update sit between the input register and the
// result register, so each hit needs one pass through that logic only.
// When the receiver stalls, the result register holds its word and the input
// register takes one more hit; after that i_hit.ready drops until o_coinc moves.
// Reset (i_rst_n low, synchronous) empties both registers, closes any open group
// and loads the default window of 20 ns and channel ids 681 to 684. The user must
// write registers via APB only while the block is idle; nothing here enforces it.
`timescale 1ns / 1ps
`default_nettype none

module hit_coincidence_grouper_unit #(
    parameter int TIME_BITS        = 48,
    parameter int MAX_MULTIPLICITY = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hcg_hit_if.sink                        i_hit,
    hcg_coinc_if.source                    o_coinc,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcg_pkg::HCG_ADDR_W-1:0] paddr,
    input  logic [hcg_pkg::HCG_DATA_W-1:0] pwdata,
    output logic [hcg_pkg::HCG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import hcg_pkg::*;

    // Port times are 48 bits wide, so a larger TIME_BITS adds no stored bits.
    localparam int TimeW = (TIME_BITS < HCG_TIME_W) ? TIME_BITS : HCG_TIME_W;

    t_cfg w_cfg;
    t_hit w_hit;
    logic w_hit_valid;
    logic w_hit_ready;

    // Configuration registers; pready is tied high, so writes see no wait states.
    hcg_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register with the channel match folded into its load path.
    hcg_hit_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_hit.valid),
        .o_ready      (i_hit.ready),
        .i_channel_id (i_hit.channel_id),
        .i_hit_time   (i_hit.hit_time),
        .i_last_hit   (i_hit.last_hit),
        .o_valid      (w_hit_valid),
        .i_ready      (w_hit_ready),
        .o_hit        (w_hit)
    );

    // Group state and the result register that feeds o_coinc.
    hcg_group_core #(
        .TIME_W   (TimeW),
        .MAX_MULT (MAX_MULTIPLICITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_hit_valid),
        .o_ready     (w_hit_ready),
        .i_hit       (w_hit),
        .o_out_valid (o_coinc.valid),
        .i_out_ready (o_coinc.ready),
        .o_out_time  (o_coinc.coincidence_time),
        .o_out_mult  (o_coinc.multiplicity)
    );

endmodule

`default_nettype wire

[rtl/core/hcg_checker.sv]
// Port-level checks of the grouper, bound onto hit_coincidence_grouper_unit.
// Depends on hcg_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module hcg_checker #(
    parameter int MAX_MULTIPLICITY = 4
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [hcg_pkg::HCG_TIME_W-1:0] i_out_time,
    input logic [hcg_pkg::HCG_MULT_W-1:0] i_out_mult,
    input logic                           i_psel,
    input logic                           i_penable,
    input logic                           i_pwrite,
    input logic [hcg_pkg::HCG_ADDR_W-1:0] i_paddr,
    input logic [hcg_pkg::HCG_DATA_W-1:0] i_pwdata,
    input logic [hcg_pkg::HCG_DATA_W-1:0] i_prdata
);
    import hcg_pkg::*;

    localparam logic [HCG_MULT_W-1:0] MaxSize = HCG_MULT_W'(MAX_MULTIPLICITY);

    // A reported group always holds at least two hits and never more than the cap.
    a_mult_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_mult >= HCG_MULT_W'(2)) && (i_out_mult <= MaxSize))
        else $error("coincidence multiplicity out of range");

    // A stalled coincidence word keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_time) && $stable(i_out_mult))
        else $error("stalled coincidence word changed");

    // Nothing is reported in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("coincidence word valid after reset");

    // A window write followed by a window read returns the written value.
    a_window_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite &&
            i_paddr[HCG_ADDR_W-1:2] == REG_WINDOW) ##1
        (i_psel && i_penable && !i_pwrite &&
            i_paddr[HCG_ADDR_W-1:2] == REG_WINDOW) |->
        i_prdata == HCG_DATA_W'($past(i_pwdata[HCG_CH_W-1:0])))
        else $error("window register readback mismatch");

endmodule

bind hit_coincidence_grouper_unit hcg_checker #(
    .MAX_MULTIPLICITY (MAX_MULTIPLICITY)
) u_hcg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_coinc.valid),
    .i_out_ready (o_coinc.ready),
    .i_out_time  (o_coinc.coincidence_time),
    .i_out_mult  (o_coinc.multiplicity),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire

[sim/hit_coincidence_grouper_unit_test.sv]
// Self-checking testbench for hit_coincidence_grouper_unit: directed grouping cases,
// register extremes and long random hit streams under varied handshake idling.
// Depends on hcg_pkg, hcg_if and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module hit_coincidence_grouper_unit_test;

    import hcg_pkg::*;

    localparam int MAX_GROUP      = 4;
    localparam int HITS_PER_PHASE = 480;  // counted hits (on a programmed channel) per phase
    localparam int SETTLE_CYCLES  = 4;    // a little over the two register stages
    localparam logic [HCG_TIME_W-1:0] TIME_MAX = '1;

    // Register slots past the end of the map; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [HCG_TIME_W-1:0] start;
        logic [HCG_MULT_W-1:0] size;
    } t_coinc_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [HCG_ADDR_W-1:0] paddr;
    logic [HCG_DATA_W-1:0] pwdata;
    logic [HCG_DATA_W-1:0] prdata;
    logic                  pready;

    hcg_hit_if   hit_ch();
    hcg_coinc_if coinc_ch();

    hit_coincidence_grouper_unit #(
        .TIME_BITS       (HCG_TIME_W),
        .MAX_MULTIPLICITY(MAX_GROUP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_hit  (hit_ch),
        .o_coinc(coinc_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the programmed registers and of the open group, as the block
    // should hold them after every accepted hit word.
    logic [HCG_CH_W-1:0]   cfg_window;
    logic [HCG_CH_W-1:0]   cfg_chan [HCG_NUM_CH];
    logic [HCG_TIME_W-1:0] grp_start;
    int                    grp_size;

    // Coincidence words predicted but not yet seen on o_coinc, oldest first.
    t_coinc_word pending_coinc[$];

    int tx_idle_pct = 16;
    int rx_idle_pct = 71;
    int mismatches  = 0;
    int coinc_seen  = 0;
    int hits_sent   = 0;
    int reg_writes  = 0;

    logic [HCG_TIME_W-1:0] stream_time;

    function automatic logic chan_enabled(input logic [HCG_CH_W-1:0] ch);
        return ch == cfg_chan[0] || ch == cfg_chan[1] || ch == cfg_chan[2] || ch == cfg_chan[3];
    endfunction

    // Advances the group state by one hit word. Returns 1 and fills word when
    // the hit closes a group of two or more.
    function automatic logic fold_hit_into_group(input logic [HCG_CH_W-1:0] ch,
                                                 input logic [HCG_TIME_W-1:0] t,
                                                 input logic last,
                                                 output t_coinc_word word);
        logic [HCG_TIME_W-1:0] gap;
        logic                  fired;
        fired = 1'b0;
        word  = '0;
        if (chan_enabled(ch)) begin
            if (grp_size == 0) begin
                grp_start = t;
                grp_size  = 1;
            end else begin
                // Distance is taken both ways, so a late-arriving earlier hit can join.
                gap = (t >= grp_start) ? t - grp_start : grp_start - t;
                if (gap < HCG_TIME_W'(cfg_window)) begin
                    grp_size++;
                    if (grp_size >= MAX_GROUP) begin
                        word  = '{start: grp_start, size: HCG_MULT_W'(grp_size)};
                        fired = 1'b1;
                        grp_size = 0;
                    end
                end else begin
                    if (grp_size >= 2) begin
                        word  = '{start: grp_start, size: HCG_MULT_W'(grp_size)};
                        fired = 1'b1;
                    end
                    grp_start = t;
                    grp_size  = 1;
                end
            end
        end
        // The last marker flushes whatever is open, even on a dropped hit; a
        // group that already reported on this hit is not reported twice.
        if (last) begin
            if (grp_size >= 2 && !fired) begin
                word  = '{start: grp_start, size: HCG_MULT_W'(grp_size)};
                fired = 1'b1;
            end
            grp_size = 0;
        end
        return fired;
    endfunction

    function automatic void apply_reg_write(input logic [2:0] idx, input logic [HCG_CH_W-1:0] v);
        unique case (idx)
            REG_WINDOW: cfg_window  = v;
            REG_CH_A:   cfg_chan[0] = v;
            REG_CH_B:   cfg_chan[1] = v;
            REG_CH_C:   cfg_chan[2] = v;
            REG_CH_D:   cfg_chan[3] = v;
            default: ;
        endcase
    endfunction

    // APB write: setup cycle, then access cycle until pready, then the bus goes
    // idle. The upper half of pwdata carries noise, since only the low 16
    // bits belong to a register.
    task automatic write_reg(input logic [2:0] idx, input logic [HCG_CH_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg_write(idx, value);
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Presents one hit word, starting at a falling edge, after a random number
    // of idle cycles. Valid is left high so back-to-back words need no gap.
    task automatic send_hit(input logic [HCG_CH_W-1:0] ch, input logic [HCG_TIME_W-1:0] t,
                            input logic last);
        t_coinc_word word;
        while ($urandom_range(99) < tx_idle_pct) begin
            hit_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        hit_ch.valid      <= 1'b1;
        hit_ch.channel_id <= ch;
        hit_ch.hit_time   <= t;
        hit_ch.last_hit   <= last;
        do @(posedge i_clk); while (!hit_ch.ready);
        if (fold_hit_into_group(ch, t, last, word))
            pending_coinc = {pending_coinc, word};
        hits_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits for every predicted word, then lets the pipeline
    // settle so that a hit with no result is also fully absorbed.
    task automatic wait_for_idle();
        hit_ch.valid <= 1'b0;
        while (pending_coinc.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Hand-picked hits under the reset register values (window 320, channels
    // 681 to 684): window edges, out-of-order time, dropped hits, flushes.
    task automatic test_default_grouping();
        send_hit(16'd681, 48'd1000, 1'b0);
        send_hit(16'd682, 48'd1319, 1'b0);      // one tick inside the window
        send_hit(16'd999, 48'd1320, 1'b0);      // foreign channel, dropped
        send_hit(16'd683, 48'd1320, 1'b0);      // exactly on the window, new group
        send_hit(16'd684, 48'd1320, 1'b0);
        send_hit(16'd681, 48'd1200, 1'b0);      // earlier than the first hit, still joins
        send_hit(16'd682, 48'd1639, 1'b0);      // fourth hit closes the group
        send_hit(16'd683, 48'd5000, 1'b1);      // lone hit flushed, nothing reported
        send_hit(16'd0,   48'd6000, 1'b0);
        send_hit(16'd681, 48'd7000, 1'b0);
        send_hit(16'd681, 48'd7001, 1'b0);
        send_hit(16'hFFFF, 48'd7002, 1'b1);     // dropped hit still flushes the pair
        send_hit(16'd682, 48'd8000, 1'b0);
        send_hit(16'd683, 48'd8100, 1'b0);
        send_hit(16'd684, 48'd9000, 1'b1);      // old pair reports, new lone hit dies
        send_hit(16'd681, TIME_MAX - 48'd100, 1'b0);
        send_hit(16'd682, TIME_MAX, 1'b0);
        send_hit(16'd683, TIME_MAX, 1'b0);
        send_hit(16'd684, 48'd0, 1'b0);         // far outside, triple reports
        send_hit(16'd681, 48'd0, 1'b1);
        send_hit(16'd681, 48'd100, 1'b0);
        send_hit(16'd682, 48'd101, 1'b0);
        send_hit(16'd683, 48'd102, 1'b0);
        send_hit(16'd684, 48'd103, 1'b1);       // full group and last on one hit
        wait_for_idle();
    endtask

    // A zero window lets no hit join. All four ids are the same, and writes to
    // the spare register slots must leave the map untouched.
    task automatic test_zero_window_duplicates();
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_CH_A, 16'h1234);
        write_reg(REG_CH_B, 16'h1234);
        write_reg(REG_CH_C, 16'h1234);
        write_reg(REG_CH_D, 16'h1234);
        write_reg(REG_SPARE_LO, 16'h5A5A);
        write_reg(REG_SPARE_HI, 16'hA5A5);
        send_hit(16'h1234, 48'd50, 1'b0);
        send_hit(16'h1234, 48'd50, 1'b0);
        send_hit(16'h1234, 48'd50, 1'b1);
        wait_for_idle();
    endtask

    // Long random stream under one register setting and one idling profile.
    // Most hits land inside the window of the open group so that groups fill,
    // with window-edge hits, big jumps, out-of-order hits and foreign channels
    // mixed in. Halfway through, the sender holds off until all words are back.
    task automatic test_random_stream(input int tx_pct, input int rx_pct,
                                      input logic [HCG_CH_W-1:0] window,
                                      input logic [HCG_CH_W-1:0] ch_a,
                                      input logic [HCG_CH_W-1:0] ch_b,
                                      input logic [HCG_CH_W-1:0] ch_c,
                                      input logic [HCG_CH_W-1:0] ch_d);
        int                    counted;
        int                    win;
        int                    pick;
        logic                  paused;
        logic [HCG_CH_W-1:0]   ch;
        wait_for_idle();
        write_reg(REG_WINDOW, window);
        write_reg(REG_CH_A, ch_a);
        write_reg(REG_CH_B, ch_b);
        write_reg(REG_CH_C, ch_c);
        write_reg(REG_CH_D, ch_d);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        win         = int'(cfg_window);
        stream_time = 48'({$urandom, $urandom});
        counted     = 0;
        paused      = 1'b0;
        while (counted < HITS_PER_PHASE) begin
            if (!paused && counted >= HITS_PER_PHASE / 2) begin
                wait_for_idle();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                stream_time += 48'($urandom_range(win / 3));
            else if (pick < 75)
                stream_time += 48'($urandom_range(2 * win));
            else if (pick < 85)
                stream_time = grp_start + HCG_TIME_W'(cfg_window) - 48'($urandom_range(1));
            else if (pick < 92)
                stream_time += 48'({$urandom, $urandom});
            else
                stream_time -= 48'($urandom_range(win));
            ch = ($urandom_range(99) < 85) ? cfg_chan[$urandom_range(HCG_NUM_CH - 1)]
                                           : 16'($urandom);
            if (chan_enabled(ch))
                counted++;
            send_hit(ch, stream_time, $urandom_range(19) == 0);
        end
        wait_for_idle();
    endtask

    // The receiver stalls at random; ready changes only at falling edges.
    always @(negedge i_clk)
        coinc_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Every coincidence word that moves is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_coinc_word want;
        if (i_rst_n && coinc_ch.valid && coinc_ch.ready) begin
            coinc_seen++;
            if (pending_coinc.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected coincidence word, expected none, got time %h size %0d",
                         $time, coinc_ch.coincidence_time, coinc_ch.multiplicity);
            end else begin
                want = pending_coinc.pop_front();
                if (coinc_ch.coincidence_time !== want.start) begin
                    mismatches++;
                    $display("%0t: coincidence_time mismatch, expected %h, got %h",
                             $time, want.start, coinc_ch.coincidence_time);
                end
                if (coinc_ch.multiplicity !== want.size) begin
                    mismatches++;
                    $display("%0t: multiplicity mismatch, expected %0d, got %0d",
                             $time, want.size, coinc_ch.multiplicity);
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        hit_ch.valid      = 1'b0;
        hit_ch.channel_id = '0;
        hit_ch.hit_time   = '0;
        hit_ch.last_hit   = 1'b0;
        coinc_ch.ready    = 1'b0;
        cfg_window        = HCG_WINDOW_RST;
        cfg_chan[0]       = HCG_CH_A_RST;
        cfg_chan[1]       = HCG_CH_B_RST;
        cfg_chan[2]       = HCG_CH_C_RST;
        cfg_chan[3]       = HCG_CH_D_RST;
        grp_start         = '0;
        grp_size          = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_grouping();
        test_zero_window_duplicates();
        // Widest window with the extreme channel ids, sender mostly busy.
        test_random_stream(16, 71, 16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom));
        // Narrowest useful window with paired duplicate ids, receiver mostly ready.
        test_random_stream(71, 16, 16'd1, 16'h00FF, 16'h00FF, 16'hFF00, 16'hFF00);
        // Mid-size window, no idling on either side.
        test_random_stream(0, 0, 16'($urandom_range(4000, 2)), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));

        wait_for_idle();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d hit words over %0d register writes (zero, unit and full windows).",
                 hits_sent, reg_writes);
        $display("Checked %0d coincidence words under three idling profiles.", coinc_seen);
        if (mismatches == 0 && pending_coinc.size() == 0) begin
            $display("** hit_coincidence_grouper_unit: PASSED **");
        end else begin
            $display("** hit_coincidence_grouper_unit: FAILED **");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d coincidence words still expected.", pending_coinc.size());
        $display("** hit_coincidence_grouper_unit: FAILED **");
        $finish;
    end

endmodule
